FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/deqr_pkg.sv
package deqr_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_WIDTH_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int KIND_W   = 2;
  localparam int ITAG_W   = 16;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_TAIL = 2'd0,
    KIND_PUSH_HEAD = 2'd1,
    KIND_POP_HEAD  = 2'd2,
    KIND_REMOVE    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_APPLY
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_COMPARE,
    CMD_PUSH_TAIL,
    CMD_PUSH_HEAD,
    CMD_CLOSE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      take_next;
  } cell_ctl_t;

endpackage

FILE: src/deqr_if.sv
interface deqr_req_if;
  import deqr_pkg::*;

  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [ITAG_W-1:0]   item_tag;

  modport source(output valid, kind, item_tag, input ready);
  modport sink(input valid, kind, item_tag, output ready);
endinterface

interface deqr_rsp_if;
  import deqr_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [ITAG_W-1:0]   popped_tag;
  logic [OCC_W-1:0]    occupancy;

  modport source(output valid, status, popped_tag, occupancy, input ready);
  modport sink(input valid, status, popped_tag, occupancy, output ready);
endinterface

FILE: src/double_ended_queue_with_removal_top.sv
// Bounded double-ended queue of nonzero tags held in a row of DEPTH cells, head in cell 0.
// Requests push at the tail, push at the head, pop the head, or remove the first entry
// from the head that equals a tag; each request gives exactly one response with status,
// popped tag and the occupancy after the request. One request is worked on at a time:
// pushes and pops go from acceptance to the apply state, a removal first passes a match
// state because every cell first registers its own tag compare before the row closes the
// gap. A new request is accepted while a response is still waiting; the apply state waits
// only while an earlier response has not been taken. Slot contents need no reset or
// clearing pass; only the fill count is reset.
module double_ended_queue_with_removal_top #(
  parameter int DEPTH     = deqr_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = deqr_pkg::TAG_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  deqr_req_if.sink   req,
  deqr_rsp_if.source rsp
);
  import deqr_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  state_t               state, state_next;
  kind_t                kind_q;
  logic [TAG_WIDTH-1:0] key_q;
  logic [CW-1:0]        count, count_next;
  logic                 rsp_valid;
  status_t              status_q, status_next;
  logic [ITAG_W-1:0]    popped_q, popped_next;

  cell_cmd_t            cmd;
  logic                 apply;
  logic                 take_all;
  logic [DEPTH-1:0]     hit_vec;
  logic [DEPTH-1:0]     close_mask;

  logic [TAG_WIDTH-1:0] cell_data [DEPTH];
  logic [TAG_WIDTH-1:0] prev_d    [DEPTH];
  logic [TAG_WIDTH-1:0] next_d    [DEPTH];
  cell_ctl_t            cell_ctl  [DEPTH];

  // On a removal, every cell at or beyond the first match takes its tail-side neighbor; on a pop, every cell does.
  assign close_mask = take_all ? '1 : (hit_vec | (~hit_vec + DEPTH'(1)));

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_d[g] = cell_data[g];
    end else begin : g_mid
      assign prev_d[g] = cell_data[g-1];
    end
    if (g == DEPTH-1) begin : g_tail
      assign next_d[g] = cell_data[g];
    end else begin : g_body
      assign next_d[g] = cell_data[g+1];
    end

    assign cell_ctl[g].cmd       = cmd;
    assign cell_ctl[g].take_next = close_mask[g];

    deqr_cell #(
      .TAG_WIDTH (TAG_WIDTH),
      .DEPTH     (DEPTH),
      .IDX       (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .key       (key_q),
      .count     (count),
      .prev_data (prev_d[g]),
      .next_data (next_d[g]),
      .data      (cell_data[g]),
      .hit       (hit_vec[g])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.kind == KIND_REMOVE) ? S_MATCH : S_APPLY;
        end
      end
      S_MATCH: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (apply) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and cell commands.
  always_comb begin
    req.ready   = 1'b0;
    cmd         = CMD_NONE;
    apply       = 1'b0;
    take_all    = 1'b0;
    status_next = ST_OK;
    popped_next = '0;
    count_next  = count;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_MATCH: begin
        cmd = CMD_COMPARE;
      end
      S_APPLY: begin
        if (!rsp_valid || rsp.ready) begin
          apply = 1'b1;
          case (kind_q) inside
            KIND_PUSH_TAIL, KIND_PUSH_HEAD: begin
              if (key_q == '0) begin
                status_next = ST_NULL;
              end else if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                cmd        = (kind_q == KIND_PUSH_TAIL) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
                count_next = count + CW'(1);
              end
            end
            KIND_POP_HEAD: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                cmd         = CMD_CLOSE;
                take_all    = 1'b1;
                popped_next = ITAG_W'(cell_data[0]);
                count_next  = count - CW'(1);
              end
            end
            default: begin
              if (|hit_vec) begin
                cmd        = CMD_CLOSE;
                count_next = count - CW'(1);
              end else begin
                status_next = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply) begin
        rsp_valid <= 1'b1;
        count     <= count_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_q <= req.kind;
      key_q  <= TAG_WIDTH'(req.item_tag);
    end
    if (apply) begin
      status_q <= status_next;
      popped_q <= popped_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = status_q;
  assign rsp.popped_tag = popped_q;
  assign rsp.occupancy  = OCC_W'(count);

endmodule

FILE: src/deqr_cell.sv
module deqr_cell #(
  parameter int TAG_WIDTH = deqr_pkg::TAG_WIDTH_DEF,
  parameter int DEPTH     = deqr_pkg::DEPTH_DEF,
  parameter int IDX       = 0
) (
  input  logic                         clk,
  input  deqr_pkg::cell_ctl_t          ctl,
  input  logic [TAG_WIDTH-1:0]         key,
  input  logic [$clog2(DEPTH+1)-1:0]   count,
  input  logic [TAG_WIDTH-1:0]         prev_data,
  input  logic [TAG_WIDTH-1:0]         next_data,
  output logic [TAG_WIDTH-1:0]         data,
  output logic                         hit
);
  import deqr_pkg::*;

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] POS = CW'(IDX);

  // Slot contents carry no reset; only entries below the fill count are read.
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_COMPARE: begin
        hit <= (count > POS) && (data == key);
      end
      CMD_PUSH_TAIL: begin
        if (count == POS) begin
          data <= key;
        end
      end
      CMD_PUSH_HEAD: begin
        data <= (IDX == 0) ? key : prev_data;
      end
      CMD_CLOSE: begin
        if (ctl.take_next) begin
          data <= next_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/deqr_chk.sv
`include "assert_macros.svh"

module deqr_chk #(
  parameter int DEPTH = deqr_pkg::DEPTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input deqr_pkg::status_t              status,
  input logic [deqr_pkg::ITAG_W-1:0]    popped_tag,
  input logic [deqr_pkg::OCC_W-1:0]     occupancy
);
  import deqr_pkg::*;

  // A waiting response keeps its contents until it is taken.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(popped_tag) && $stable(occupancy), "response changed while stalled")

  // Only one request is in progress at a time.
  `ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "request accepted while another is in progress")

  // An empty report leaves nothing in the queue.
  `ASSERT_IMPLIES(a_empty_occ, clk, rst, rsp_valid && (status == ST_EMPTY), occupancy == '0, "empty status with nonzero occupancy")

  // A nonzero popped tag comes only from a successful pop.
  `ASSERT_IMPLIES(a_pop_ok, clk, rst, rsp_valid && (popped_tag != '0), status == ST_OK, "popped tag on a failed request")

  // The reported occupancy never exceeds the number of cells.
  `ASSERT_IMPLIES(a_occ_max, clk, rst, rsp_valid, int'(occupancy) <= DEPTH, "occupancy above depth")

endmodule

bind double_ended_queue_with_removal_top deqr_chk #(.DEPTH(DEPTH)) u_deqr_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .popped_tag (rsp.popped_tag),
  .occupancy  (rsp.occupancy)
);
